// ----- src/pdcd_pkg.sv -----
// shared types, constants and color upscale function for the palette chunk decoder
`default_nettype none

package pdcd_pkg;

	localparam int unsigned PALETTE_ENTRIES_DEF = 256;

	localparam logic [7:0] SKIP_FLAG   = 8'h80;
	localparam logic [7:0] SKIP_MASK   = 8'h7f;
	localparam logic [7:0] COPY_FLAG   = 8'h40;
	localparam logic [7:0] VALUE_MASK  = 8'h3f;
	localparam int unsigned UPSCALE_DIV = 16;

	typedef struct packed {
		logic take;
		logic start;
		logic skip;
		logic set_copy;
		logic set_src;
		logic set_red;
		logic set_green;
		logic set_blue;
		logic mem_read;
		logic copy_wr;
		logic copy_drop;
		logic blue_wr;
		logic null_out;
		logic mark_last;
		logic mark_done;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic byte_zero;
		logic byte_skip;
		logic byte_copy;
		logic rem_one;
		logic pos_full;
		logic cnt_zero;
		logic copy_ok;
		logic copy_last;
		logic out_free;
	} dp_status_t;

	function automatic logic [7:0] upscale(input logic [5:0] v);
		logic [7:0] wide;
		wide = {v, 2'b00};
		return wide + 8'(v / UPSCALE_DIV);
	endfunction

endpackage

`default_nettype wire

// ----- src/pdcd_datapath.sv -----
// palette datapath: double-banked palette memory, counters and output register
`default_nettype none

module pdcd_datapath #(
	parameter int unsigned PALETTE_ENTRIES = pdcd_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pdcd_pkg::dp_cmd_t    cmd,
	output pdcd_pkg::dp_status_t      status,
	input  wire logic [7:0]           chunk_byte,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic                      entry_valid,
	output logic [7:0]                entry_index,
	output logic [7:0]                red,
	output logic [7:0]                green,
	output logic [7:0]                blue,
	output logic                      chunk_done,
	output logic                      last_of_run
);
	import pdcd_pkg::*;

	localparam int unsigned IW = $clog2(PALETTE_ENTRIES);
	localparam int unsigned PW = $clog2(PALETTE_ENTRIES + 1);
	localparam int unsigned MD = 2 ** (IW + 1);
	localparam logic [9:0] NUM = 10'(PALETTE_ENTRIES);
	localparam logic [PW-1:0] POS_MAX = PW'(PALETTE_ENTRIES);

	logic [9:0]                 rem_q;
	logic [PW-1:0]              pos_q;
	logic [8:0]                 src_q;
	logic [6:0]                 cnt_q;
	logic [5:0]                 red_q;
	logic [5:0]                 green_q;
	logic [5:0]                 blue_q;
	logic [PALETTE_ENTRIES-1:0] sel_q;
	logic [PALETTE_ENTRIES-1:0] dirty_q;
	logic [PALETTE_ENTRIES-1:0] valid_q;
	logic [23:0]                pal_mem [MD];
	logic [23:0]                rd_data_q;
	logic                       rd_ok_q;
	logic                       result_valid_q;
	logic                       entry_valid_q;
	logic [7:0]                 entry_index_q;
	logic [23:0]                rgb_q;
	logic                       chunk_done_q;
	logic                       last_of_run_q;

	logic [IW-1:0]              pos_idx;
	logic [IW-1:0]              src_idx;
	logic [9:0]                 pos_ext;
	logic [9:0]                 src_ext;
	logic [9:0]                 skip_sum;
	logic [9:0]                 pos_inc;
	logic                       wr_en;
	logic [23:0]                wr_data;
	logic [PALETTE_ENTRIES-1:0] wr_mask;
	logic [PALETTE_ENTRIES-1:0] dirty_w;

	always_comb begin
		pos_idx  = pos_q[IW-1:0];
		src_idx  = src_q[IW-1:0];
		pos_ext  = 10'(pos_q);
		src_ext  = 10'(src_q);
		skip_sum = pos_ext + 10'(chunk_byte & SKIP_MASK) + 10'd1;
		pos_inc  = pos_ext + 10'd1;

		status.byte_zero = chunk_byte == 8'd0;
		status.byte_skip = (chunk_byte & SKIP_FLAG) != 8'd0;
		status.byte_copy = (chunk_byte & COPY_FLAG) != 8'd0;
		status.rem_one   = rem_q == 10'd1;
		status.pos_full  = pos_ext >= NUM;
		status.cnt_zero  = cnt_q == 7'd0;
		status.copy_ok   = (pos_ext < NUM) && (src_ext < NUM);
		status.copy_last = (cnt_q == 7'd1) || (pos_inc >= NUM) || ((src_ext + 10'd1) >= NUM);
		status.out_free  = !result_valid_q || !result_stall;

		wr_en = cmd.copy_wr || cmd.blue_wr;
		if (cmd.copy_wr) begin
			wr_data = rd_ok_q ? rd_data_q : 24'd0;
		end else begin
			wr_data = {upscale(red_q), upscale(green_q), upscale(blue_q)};
		end
		wr_mask = '0;
		if (wr_en) begin
			wr_mask[pos_idx] = 1'b1;
		end
		dirty_w = dirty_q | wr_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q          <= '0;
			pos_q          <= '0;
			cnt_q          <= '0;
			sel_q          <= '0;
			dirty_q        <= '0;
			valid_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				rem_q <= {chunk_byte, 2'b00} - 10'd1;
			end else if (cmd.take && rem_q != 10'd0) begin
				rem_q <= rem_q - 10'd1;
			end

			if (cmd.start) begin
				pos_q <= '0;
			end else if (cmd.skip) begin
				pos_q <= (skip_sum >= NUM) ? POS_MAX : skip_sum[PW-1:0];
			end else if (cmd.copy_wr || cmd.copy_drop || cmd.blue_wr) begin
				pos_q <= (pos_inc >= NUM) ? POS_MAX : pos_inc[PW-1:0];
			end

			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.set_copy) begin
				cnt_q <= 7'(chunk_byte & VALUE_MASK) + 7'd1;
			end else if (cmd.copy_wr || cmd.copy_drop) begin
				cnt_q <= cnt_q - 7'd1;
			end

			// commit flips each written entry over to its working bank
			if (cmd.commit) begin
				sel_q   <= sel_q ^ dirty_w;
				valid_q <= valid_q | dirty_w;
				dirty_q <= '0;
			end else begin
				dirty_q <= dirty_w;
			end

			if (cmd.copy_wr || cmd.blue_wr || cmd.null_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_src) begin
			src_q <= {1'b0, chunk_byte};
		end else if (cmd.copy_wr || cmd.copy_drop) begin
			src_q <= src_q + 9'd1;
		end
		if (cmd.set_red) begin
			red_q <= chunk_byte[5:0];
		end
		if (cmd.set_green) begin
			green_q <= chunk_byte[5:0];
		end
		if (cmd.set_blue) begin
			blue_q <= chunk_byte[5:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pal_mem[{~sel_q[pos_idx], pos_idx}] <= wr_data;
		end
		if (cmd.mem_read) begin
			rd_data_q <= pal_mem[{sel_q[src_idx], src_idx}];
			rd_ok_q   <= valid_q[src_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_valid_q <= 1'b1;
			entry_index_q <= 8'(pos_idx);
			rgb_q         <= wr_data;
			chunk_done_q  <= cmd.mark_done;
			last_of_run_q <= cmd.mark_last;
		end else if (cmd.null_out) begin
			entry_valid_q <= 1'b0;
			entry_index_q <= 8'd0;
			rgb_q         <= 24'd0;
			chunk_done_q  <= 1'b1;
			last_of_run_q <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign entry_valid  = entry_valid_q;
	assign entry_index  = entry_index_q;
	assign red          = rgb_q[23:16];
	assign green        = rgb_q[15:8];
	assign blue         = rgb_q[7:0];
	assign chunk_done   = chunk_done_q;
	assign last_of_run  = last_of_run_q;

endmodule

`default_nettype wire

// ----- src/pdcd_controller.sv -----
// command parser state machine for the palette chunk decoder
`default_nettype none

module pdcd_controller (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 chunk_valid,
	output logic                      chunk_stall,
	input  wire pdcd_pkg::dp_status_t status,
	output pdcd_pkg::dp_cmd_t         cmd
);
	import pdcd_pkg::*;

	typedef enum logic [3:0] {
		ST_LEN,
		ST_CMD,
		ST_CIDX,
		ST_GREEN,
		ST_BLUE,
		ST_CP_RD,
		ST_CP_WR,
		ST_BLUE_WR,
		ST_NULL
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   done_d;
	logic   emit_q;
	logic   emit_d;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		done_d      = done_q;
		emit_d      = emit_q;
		chunk_stall = 1'b1;
		case (state_q)
			ST_LEN: begin
				chunk_stall = 1'b0;
				if (chunk_valid) begin
					cmd.take  = 1'b1;
					cmd.start = 1'b1;
					state_d   = status.byte_zero ? ST_NULL : ST_CMD;
				end
			end
			ST_CMD: begin
				chunk_stall = 1'b0;
				if (chunk_valid) begin
					cmd.take = 1'b1;
					if (status.pos_full) begin
						// palette full, byte is padding
						state_d = status.rem_one ? ST_NULL : ST_CMD;
					end else if (status.byte_skip) begin
						cmd.skip = 1'b1;
						state_d  = status.rem_one ? ST_NULL : ST_CMD;
					end else if (status.byte_copy) begin
						cmd.set_copy = 1'b1;
						state_d      = status.rem_one ? ST_NULL : ST_CIDX;
					end else begin
						cmd.set_red = 1'b1;
						state_d     = status.rem_one ? ST_NULL : ST_GREEN;
					end
				end
			end
			ST_CIDX: begin
				chunk_stall = 1'b0;
				if (chunk_valid) begin
					cmd.take    = 1'b1;
					cmd.set_src = 1'b1;
					done_d      = status.rem_one;
					emit_d      = 1'b0;
					state_d     = ST_CP_RD;
				end
			end
			ST_GREEN: begin
				chunk_stall = 1'b0;
				if (chunk_valid) begin
					cmd.take      = 1'b1;
					cmd.set_green = 1'b1;
					state_d       = status.rem_one ? ST_NULL : ST_BLUE;
				end
			end
			ST_BLUE: begin
				chunk_stall = 1'b0;
				if (chunk_valid) begin
					cmd.take     = 1'b1;
					cmd.set_blue = 1'b1;
					done_d       = status.rem_one;
					state_d      = ST_BLUE_WR;
				end
			end
			ST_CP_RD: begin
				if (status.cnt_zero) begin
					if (!done_q) begin
						state_d = ST_CMD;
					end else if (emit_q) begin
						cmd.commit = 1'b1;
						state_d    = ST_LEN;
					end else begin
						state_d = ST_NULL;
					end
				end else if (status.copy_ok) begin
					cmd.mem_read = 1'b1;
					state_d      = ST_CP_WR;
				end else begin
					cmd.copy_drop = 1'b1;
				end
			end
			ST_CP_WR: begin
				if (status.out_free) begin
					cmd.copy_wr   = 1'b1;
					cmd.mark_last = status.copy_last;
					cmd.mark_done = status.copy_last && done_q;
					emit_d        = 1'b1;
					state_d       = ST_CP_RD;
				end
			end
			ST_BLUE_WR: begin
				if (status.pos_full) begin
					state_d = done_q ? ST_NULL : ST_CMD;
				end else if (status.out_free) begin
					cmd.blue_wr   = 1'b1;
					cmd.mark_last = 1'b1;
					cmd.mark_done = done_q;
					cmd.commit    = done_q;
					state_d       = done_q ? ST_LEN : ST_CMD;
				end
			end
			ST_NULL: begin
				if (status.out_free) begin
					cmd.null_out = 1'b1;
					cmd.commit   = 1'b1;
					state_d      = ST_LEN;
				end
			end
			default: begin
				state_d = ST_LEN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LEN;
			done_q  <= 1'b0;
			emit_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			emit_q  <= emit_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/palette_delta_chunk_decoder_top.sv -----
// a color result is registered from ST_BLUE_WR after its blue beat; a copied entry is read in
// ST_CP_RD and registered from ST_CP_WR; beats are taken one per cycle while parsing, and no beat is
// taken during a copy or a result write; the copy rate is set by the registered palette read port
// a result waiting in the output register holds off the next write or empty result; beats wait meanwhile
// reset: asynchronous, active low; palette reads as all zero and the parser expects a length beat
// no clearing pass: per-entry bank select and valid bits clear at reset
`default_nettype none

module palette_delta_chunk_decoder_top #(
	parameter int unsigned PALETTE_ENTRIES = pdcd_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       chunk_valid,
	output logic            chunk_stall,
	input  wire logic [7:0] chunk_byte,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic            entry_valid,
	output logic [7:0]      entry_index,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue,
	output logic            chunk_done,
	output logic            last_of_run
);
	import pdcd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	pdcd_controller u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.chunk_valid (chunk_valid),
		.chunk_stall (chunk_stall),
		.status      (status),
		.cmd         (cmd)
	);

	pdcd_datapath #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.chunk_byte   (chunk_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.entry_valid  (entry_valid),
		.entry_index  (entry_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.chunk_done   (chunk_done),
		.last_of_run  (last_of_run)
	);

endmodule

`default_nettype wire

// ----- src/pdcd_checker.sv -----
// port-level assertions for the palette chunk decoder, bound to the top level
`default_nettype none

module pdcd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       result_valid,
	input wire logic       result_stall,
	input wire logic       entry_valid,
	input wire logic [7:0] entry_index,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue,
	input wire logic       chunk_done,
	input wire logic       last_of_run
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(entry_index)
			&& $stable(red) && $stable(green) && $stable(blue) && $stable(chunk_done))
		else $error("stalled result beat changed");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && chunk_done |-> last_of_run)
		else $error("chunk end not flagged as last of run");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !entry_valid |-> chunk_done && entry_index == 8'd0
			&& red == 8'd0 && green == 8'd0 && blue == 8'd0)
		else $error("empty result beat carries data");

	// every stored color is an upscaled 6-bit value
	a_upscale: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && entry_valid |-> red[1:0] == red[7:6]
			&& green[1:0] == green[7:6] && blue[1:0] == blue[7:6])
		else $error("color not an upscaled value");

endmodule

bind palette_delta_chunk_decoder_top pdcd_checker u_pdcd_checker (.*);

`default_nettype wire
